FILE: hw/rtl/rrp_pkg.sv
// shared constants, types and helper functions for the ranging result processor
`default_nettype none
package rrp_pkg;

  localparam int unsigned DataW      = 16;
  localparam int unsigned StatusW    = 4;
  localparam int unsigned RawW       = 8;
  localparam int unsigned RateW      = 32;
  localparam int unsigned BitsPerStg = 4;
  localparam int unsigned Div1Stages = RateW / BitsPerStg;
  localparam int unsigned Div2Stages = DataW / BitsPerStg;
  localparam int unsigned Latency    = 1 + Div1Stages + 1 + Div2Stages;

  localparam int unsigned ProdW      = 27;
  localparam logic [ProdW-1:0] GainFactor = ProdW'(2011);
  localparam logic [ProdW-1:0] GainRound  = ProdW'(1024);
  localparam int unsigned      GainShift  = 11;

  localparam logic [DataW-1:0] SpadsFallback = 16'h8000;
  localparam logic [DataW-1:0] Sat16         = 16'hFFFF;
  localparam logic [DataW-1:0] TargetReset   = 16'd2560;

  // raw device status codes
  localparam logic [RawW-1:0] RawHwA     = 8'd1;
  localparam logic [RawW-1:0] RawHwB     = 8'd2;
  localparam logic [RawW-1:0] RawHwC     = 8'd3;
  localparam logic [RawW-1:0] RawSignal  = 8'd4;
  localparam logic [RawW-1:0] RawBounds  = 8'd5;
  localparam logic [RawW-1:0] RawSigma   = 8'd6;
  localparam logic [RawW-1:0] RawWrap    = 8'd7;
  localparam logic [RawW-1:0] RawMinclip = 8'd8;
  localparam logic [RawW-1:0] RawDone    = 8'd9;
  localparam logic [RawW-1:0] RawXtalk   = 8'd12;
  localparam logic [RawW-1:0] RawMinrng  = 8'd13;
  localparam logic [RawW-1:0] RawHwD     = 8'd17;
  localparam logic [RawW-1:0] RawSync    = 8'd18;

  typedef enum logic [StatusW-1:0] {
    ST_VALID    = 4'd0,
    ST_SIGMA    = 4'd1,
    ST_SIGNAL   = 4'd2,
    ST_MINCLIP  = 4'd3,
    ST_BOUNDS   = 4'd4,
    ST_HW       = 4'd5,
    ST_NOWRAP   = 4'd6,
    ST_WRAP     = 4'd7,
    ST_XTALK    = 4'd8,
    ST_SYNC     = 4'd9,
    ST_MINRANGE = 4'd10,
    ST_NONE     = 4'd11
  } range_status_e;

  function automatic range_status_e map_status(input logic [RawW-1:0] raw,
                                               input logic [RawW-1:0] stream);
    range_status_e st;
    unique case (raw)
      RawHwA, RawHwB, RawHwC, RawHwD: st = ST_HW;
      RawMinrng:  st = ST_MINRANGE;
      RawSync:    st = ST_SYNC;
      RawBounds:  st = ST_BOUNDS;
      RawSignal:  st = ST_SIGNAL;
      RawSigma:   st = ST_SIGMA;
      RawWrap:    st = ST_WRAP;
      RawXtalk:   st = ST_XTALK;
      RawMinclip: st = ST_MINCLIP;
      RawDone:    st = (stream == '0) ? ST_NOWRAP : ST_VALID;
      default:    st = ST_NONE;
    endcase
    return st;
  endfunction

  // four restoring steps, 16 bit divisor; returns {remainder, quotient bits}
  function automatic logic [DataW+BitsPerStg-1:0] div_step_a(
      input logic [DataW-1:0] rem, input logic [BitsPerStg-1:0] bits,
      input logic [DataW-1:0] dvs);
    logic [DataW:0]          r;
    logic [BitsPerStg-1:0]   q;
    r = {1'b0, rem};
    q = '0;
    for (int i = BitsPerStg - 1; i >= 0; i--) begin
      r = {r[DataW-1:0], bits[i]};
      if (r >= {1'b0, dvs}) begin
        r = r - {1'b0, dvs};
        q[i] = 1'b1;
      end
    end
    return {r[DataW-1:0], q};
  endfunction

  // four restoring steps, 32 bit divisor, zero bits shifted in
  function automatic logic [RateW+BitsPerStg-1:0] div_step_b(
      input logic [RateW-1:0] rem, input logic [RateW-1:0] dvs);
    logic [RateW:0]        r;
    logic [BitsPerStg-1:0] q;
    r = {1'b0, rem};
    q = '0;
    for (int i = BitsPerStg - 1; i >= 0; i--) begin
      r = {r[RateW-1:0], 1'b0};
      if (r >= {1'b0, dvs}) begin
        r = r - {1'b0, dvs};
        q[i] = 1'b1;
      end
    end
    return {r[RateW-1:0], q};
  endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/ranging_result_processor.sv
// top level of the ranging result processor: gain, status map and spad request pipeline
`default_nettype none
// a start beat's done_o strobe comes out of the entry register, divider one, the check register and divider two
// throughput: one beat per cycle, busy never rises; the two pipelined
//   restoring dividers (8 stages and 4 stages, four quotient bits each) set the depth
// reset: valid bits clear at once, target rate returns to 2560; no clearing pass
// results cannot be stalled, so every stage simply advances each cycle
module ranging_result_processor (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start,
  output logic                            busy,
  input  wire logic [rrp_pkg::RawW-1:0]   raw_status_i,
  input  wire logic [rrp_pkg::RawW-1:0]   stream_cnt_i,
  input  wire logic [rrp_pkg::DataW-1:0]  effective_spads_i,
  input  wire logic [rrp_pkg::DataW-1:0]  ambient_rate_i,
  input  wire logic [rrp_pkg::DataW-1:0]  raw_range_i,
  input  wire logic [rrp_pkg::DataW-1:0]  peak_rate_i,
  input  wire logic                       cfg_valid_i,
  output logic                            cfg_ready_o,
  input  wire logic [rrp_pkg::DataW-1:0]  cfg_data_i,
  output logic                            done_o,
  output logic [rrp_pkg::DataW-1:0]       corr_range_o,
  output logic [rrp_pkg::StatusW-1:0]     range_status_o,
  output logic [rrp_pkg::DataW-1:0]       spads_request_o
);
  import rrp_pkg::*;

  // never stalls: a new beat may enter every cycle
  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;

  logic [DataW-1:0] target_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q <= TargetReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      target_q <= cfg_data_i;
    end
  end

  // ---------------- entry stage: gain multiply, status map, rate sum ----------------
  logic             accept;
  logic [ProdW-1:0] prod;
  logic [DataW:0]   rate_sum;
  logic [DataW-1:0] rate_sat;

  assign accept   = start && !busy;
  assign prod     = ProdW'(raw_range_i) * GainFactor + GainRound;
  assign rate_sum = {1'b0, peak_rate_i} + {1'b0, ambient_rate_i};
  assign rate_sat = rate_sum[DataW] ? Sat16 : rate_sum[DataW-1:0];

  // divider one: (rate_sat << 16) / spads, four quotient bits per stage
  logic                v1_q   [0:Div1Stages];
  logic [DataW-1:0]    rng1_q [0:Div1Stages];
  logic [StatusW-1:0]  st1_q  [0:Div1Stages];
  logic [RateW-1:0]    num1_q [0:Div1Stages];
  logic [DataW-1:0]    rem1_q [0:Div1Stages];
  logic [RateW-1:0]    quo1_q [0:Div1Stages];
  logic [DataW-1:0]    dvs1_q [0:Div1Stages];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i <= Div1Stages; i++) v1_q[i] <= 1'b0;
    end else begin
      v1_q[0] <= accept;
      for (int i = 1; i <= Div1Stages; i++) v1_q[i] <= v1_q[i-1];
    end
  end

  logic [DataW+BitsPerStg-1:0] step1 [1:Div1Stages];

  always_comb begin
    for (int i = 1; i <= Div1Stages; i++) begin
      step1[i] = div_step_a(rem1_q[i-1], num1_q[i-1][RateW-1 -: BitsPerStg],
                            dvs1_q[i-1]);
    end
  end

  always_ff @(posedge clk_i) begin
    rng1_q[0] <= prod[GainShift +: DataW];
    st1_q[0]  <= StatusW'(map_status(raw_status_i, stream_cnt_i));
    num1_q[0] <= {rate_sat, {DataW{1'b0}}};
    rem1_q[0] <= '0;
    quo1_q[0] <= '0;
    dvs1_q[0] <= effective_spads_i;
    for (int i = 1; i <= Div1Stages; i++) begin
      rng1_q[i] <= rng1_q[i-1];
      st1_q[i]  <= st1_q[i-1];
      num1_q[i] <= num1_q[i-1] << BitsPerStg;
      rem1_q[i] <= step1[i][DataW+BitsPerStg-1:BitsPerStg];
      quo1_q[i] <= {quo1_q[i-1][RateW-BitsPerStg-1:0], step1[i][BitsPerStg-1:0]};
      dvs1_q[i] <= dvs1_q[i-1];
    end
  end

  // ---------------- check stage: fallback and saturation ----------------
  // zero spads gives an all-ones quotient here, so it is flagged on the divisor
  logic [RateW-1:0] rate_div;
  logic             fb_c, sat_c;

  assign rate_div = quo1_q[Div1Stages];
  assign fb_c     = (dvs1_q[Div1Stages] == '0) || (rate_div == '0);
  // quotient of (target << 16) / rate reaches 2^16 exactly when target >= rate
  assign sat_c    = {{(RateW-DataW){1'b0}}, target_q} >= rate_div;

  // divider two: remainder starts at target (< rate), 16 zero bits shifted in
  logic               v2_q   [0:Div2Stages];
  logic [DataW-1:0]   rng2_q [0:Div2Stages];
  logic [StatusW-1:0] st2_q  [0:Div2Stages];
  logic               fb2_q  [0:Div2Stages];
  logic               sat2_q [0:Div2Stages];
  logic [RateW-1:0]   rem2_q [0:Div2Stages];
  logic [RateW-1:0]   dvs2_q [0:Div2Stages];
  logic [DataW-1:0]   quo2_q [0:Div2Stages];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i <= Div2Stages; i++) v2_q[i] <= 1'b0;
    end else begin
      v2_q[0] <= v1_q[Div1Stages];
      for (int i = 1; i <= Div2Stages; i++) v2_q[i] <= v2_q[i-1];
    end
  end

  logic [RateW+BitsPerStg-1:0] step2 [1:Div2Stages];

  always_comb begin
    for (int i = 1; i <= Div2Stages; i++) begin
      step2[i] = div_step_b(rem2_q[i-1], dvs2_q[i-1]);
    end
  end

  always_ff @(posedge clk_i) begin
    rng2_q[0] <= rng1_q[Div1Stages];
    st2_q[0]  <= st1_q[Div1Stages];
    fb2_q[0]  <= fb_c;
    sat2_q[0] <= sat_c;
    rem2_q[0] <= {{(RateW-DataW){1'b0}}, target_q};
    dvs2_q[0] <= rate_div;
    quo2_q[0] <= '0;
    for (int i = 1; i <= Div2Stages; i++) begin
      rng2_q[i] <= rng2_q[i-1];
      st2_q[i]  <= st2_q[i-1];
      fb2_q[i]  <= fb2_q[i-1];
      sat2_q[i] <= sat2_q[i-1];
      rem2_q[i] <= step2[i][RateW+BitsPerStg-1:BitsPerStg];
      dvs2_q[i] <= dvs2_q[i-1];
      quo2_q[i] <= {quo2_q[i-1][DataW-BitsPerStg-1:0], step2[i][BitsPerStg-1:0]};
    end
  end

  // ---------------- result ----------------
  assign done_o         = v2_q[Div2Stages];
  assign corr_range_o   = rng2_q[Div2Stages];
  assign range_status_o = st2_q[Div2Stages];
  assign spads_request_o = fb2_q[Div2Stages]  ? SpadsFallback :
                           sat2_q[Div2Stages] ? Sat16 : quo2_q[Div2Stages];

endmodule
`default_nettype wire

FILE: hw/rtl/rrp_checker.sv
// port level checks for the ranging result processor, bound to the top level
`default_nettype none
module rrp_checker (
  input wire logic                       clk_i,
  input wire logic                       rst_ni,
  input wire logic                       start,
  input wire logic                       busy,
  input wire logic [rrp_pkg::DataW-1:0]  effective_spads_i,
  input wire logic                       done_o,
  input wire logic [rrp_pkg::DataW-1:0]  corr_range_o,
  input wire logic [rrp_pkg::StatusW-1:0] range_status_o,
  input wire logic [rrp_pkg::DataW-1:0]  spads_request_o
);
  import rrp_pkg::*;

  // every strobe traces back to an accepted start beat
  a_done_has_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && !busy, Latency))
    else $error("result strobe without matching start beat");

  a_zero_spads_fallback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && $past(effective_spads_i, Latency) == '0) |-> spads_request_o == SpadsFallback)
    else $error("zero spad count did not give fallback request");

  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> range_status_o <= StatusW'(ST_NONE))
    else $error("range status out of range");

  a_range_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> corr_range_o <= 16'd64354)
    else $error("gain corrected range too large");

endmodule

bind ranging_result_processor rrp_checker u_rrp_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .start             (start),
  .busy              (busy),
  .effective_spads_i (effective_spads_i),
  .done_o            (done_o),
  .corr_range_o      (corr_range_o),
  .range_status_o    (range_status_o),
  .spads_request_o   (spads_request_o)
);
`default_nettype wire

FILE: test/testbench.sv
// testbench for the ranging result processor: directed table, then random records
`default_nettype none
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import rrp_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [RawW-1:0] raw_status_i = '0, stream_cnt_i = '0;
  logic [DataW-1:0] effective_spads_i = '0, ambient_rate_i = '0;
  logic [DataW-1:0] raw_range_i = '0, peak_rate_i = '0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [DataW-1:0] cfg_data_i = '0;
  logic done_o;
  logic [DataW-1:0] corr_range_o, spads_request_o;
  logic [StatusW-1:0] range_status_o;

  typedef struct packed {
    logic [RawW-1:0]  raw_status;
    logic [RawW-1:0]  stream_cnt;
    logic [DataW-1:0] spads;
    logic [DataW-1:0] ambient;
    logic [DataW-1:0] range_raw;
    logic [DataW-1:0] peak;
  } record_t;

  typedef struct packed {
    logic [DataW-1:0]   corr_range;
    range_status_e      status;
    logic [DataW-1:0]   request;
  } processed_t;

  // directed row: record plus optional hand-typed result
  typedef struct packed {
    record_t    rec;
    logic       typed;
    processed_t res;
  } row_t;

  logic [DataW-1:0] target_rate = TargetReset;
  processed_t pending_results[$];
  int mismatches = 0;
  int sender_idle_pct = 0;

  ranging_result_processor DUT (.*);

  always #1 clk_i = ~clk_i;

  initial begin
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // gain correction, status map and spad request for one record
  function automatic processed_t process_record(record_t r);
    processed_t p;
    logic [31:0] sum, per_spad, req;
    logic [31:0] prod;
    prod = 32'(r.range_raw) * 32'd2011 + 32'd1024;
    p.corr_range = 16'(prod >> 11);
    case (r.raw_status)
      8'd1, 8'd2, 8'd3, 8'd17: p.status = ST_HW;
      8'd13: p.status = ST_MINRANGE;
      8'd18: p.status = ST_SYNC;
      8'd5:  p.status = ST_BOUNDS;
      8'd4:  p.status = ST_SIGNAL;
      8'd6:  p.status = ST_SIGMA;
      8'd7:  p.status = ST_WRAP;
      8'd12: p.status = ST_XTALK;
      8'd8:  p.status = ST_MINCLIP;
      8'd9:  p.status = (r.stream_cnt == 0) ? ST_NOWRAP : ST_VALID;
      default: p.status = ST_NONE;
    endcase
    if (r.spads == 0) begin
      p.request = 16'h8000;
    end else begin
      sum = 32'(r.peak) + 32'(r.ambient);
      if (sum > 32'hFFFF) sum = 32'hFFFF;
      per_spad = (sum << 16) / 32'(r.spads);
      if (per_spad == 0) begin
        p.request = 16'h8000;
      end else begin
        req = ({16'b0, target_rate} << 16) / per_spad;
        p.request = (req > 32'hFFFF) ? 16'hFFFF : req[15:0];
      end
    end
    return p;
  endfunction

  // result checker: strobe is sampled at the edge that ends its cycle
  always @(posedge clk_i) begin
    processed_t got, want;
    if (rst_ni && done_o) begin
      got = '{corr_range_o, range_status_e'(range_status_o), spads_request_o};
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: range %0d/%0d status %0d/%0d request %h/%h",
                     want.corr_range, got.corr_range, want.status, got.status,
                     want.request, got.request);
        end
      end
    end
  end

  // drive one record, honoring the sender idle share
  task automatic send_record(record_t r, processed_t want);
    while ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start <= 1'b1;
    {raw_status_i, stream_cnt_i, effective_spads_i, ambient_rate_i,
     raw_range_i, peak_rate_i} <= r;
    do @(posedge clk_i); while (busy);
    pending_results.push_back(want);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (Latency + 4) @(posedge clk_i);
  endtask

  // register write while the pipeline is empty
  task automatic write_target(logic [DataW-1:0] v);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    target_rate = v;
  endtask

  function automatic logic [15:0] pick16();
    case ($urandom_range(5))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'($urandom_range(255));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic record_t random_record();
    record_t r;
    logic [7:0] known [14] = '{1, 2, 3, 4, 5, 6, 7, 8, 9, 12, 13, 17, 18, 9};
    r.raw_status = ($urandom_range(3) != 0) ? known[$urandom_range(13)]
                                            : 8'($urandom);
    r.stream_cnt = ($urandom_range(3) == 0) ? 8'h00 : 8'($urandom);
    r.spads = pick16();
    r.ambient = pick16();
    r.range_raw = pick16();
    r.peak = pick16();
    return r;
  endfunction

  row_t directed_rows[$];

  initial begin
    record_t r;
    processed_t p;
    int idle_pcts [4] = '{0, 45, 0, 26};
    // reset-rate rows with readable answers: zero spads falls back, max range
    directed_rows.push_back('{'{8'd9, 8'd0, 16'd0, 16'd0, 16'd0, 16'd0}, 1'b1,
                              '{16'd0, ST_NOWRAP, 16'h8000}});
    directed_rows.push_back('{'{8'd9, 8'd1, 16'd0, 16'd5, 16'hFFFF, 16'd5}, 1'b1,
                              '{16'd64351, ST_VALID, 16'h8000}});
    directed_rows.push_back('{'{8'd255, 8'd255, 16'd0, 16'hFFFF, 16'd1, 16'hFFFF}, 1'b1,
                              '{16'd1, ST_NONE, 16'h8000}});
    // zero rate sum gives a zero per-spad rate: fallback
    directed_rows.push_back('{'{8'd0, 8'd0, 16'hFFFF, 16'd0, 16'd0, 16'd0}, 1'b1,
                              '{16'd0, ST_NONE, 16'h8000}});
    begin
      logic [7:0] codes [13] = '{1, 2, 3, 4, 5, 6, 7, 8, 12, 13, 17, 18, 10};
      foreach (codes[i])
        directed_rows.push_back('{'{codes[i], 8'($urandom), 16'($urandom_range(1, 65535)),
                                  16'($urandom), 16'($urandom), 16'($urandom)}, 1'b0, '0});
    end
    // saturation of the rate sum, and a single spad
    directed_rows.push_back('{'{8'd9, 8'd128, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF},
                              1'b0, '0});
    directed_rows.push_back('{'{8'd9, 8'd128, 16'h0001, 16'h0000, 16'h0000, 16'h0001},
                              1'b0, '0});

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      p = directed_rows[i].typed ? directed_rows[i].res
                                 : process_record(directed_rows[i].rec);
      send_record(directed_rows[i].rec, p);
    end

    // random phases over several register settings, extremes included
    begin
      logic [15:0] rates [6] = '{16'h0000, 16'hFFFF, 16'h0001, 16'd2560, 16'h8000, 16'h1234};
      for (int ph = 0; ph < 6; ph++) begin
        write_target((ph == 5) ? 16'($urandom) : rates[ph]);
        for (int k = 0; k < 258; k++) begin
          sender_idle_pct = (k < 40) ? 0 : idle_pcts[(ph + k / 64) % 4];
          if (k == 130) drain();    // hold off until the pipe is empty
          r = random_record();
          send_record(r, process_record(r));
        end
      end
    end

    start <= 1'b0;
    fork
      wait (pending_results.size() == 0);
      begin repeat (10_000) @(posedge clk_i); end
    join_any
    repeat (Latency + 4) @(posedge clk_i);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
`default_nettype wire

FILE: sim.f
hw/rtl/rrp_pkg.sv
hw/rtl/ranging_result_processor.sv
hw/rtl/rrp_checker.sv
test/testbench.sv
